// ----- hdl/bdfs_pkg.sv -----
package bdfs_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_W   = 3'd0;
  localparam logic [2:0] REG_SRC_H   = 3'd1;
  localparam logic [2:0] REG_TGT_W   = 3'd2;
  localparam logic [2:0] REG_TGT_H   = 3'd3;
  localparam logic [2:0] REG_ONE_BIT = 3'd4;
  localparam logic [2:0] REG_DITHER  = 3'd5;
  localparam logic [2:0] REG_INVERT  = 3'd6;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 14;

  localparam logic [7:0] LUMA_MAX = 8'hFF;
  localparam logic [7:0] MASK_1B  = 8'h80;
  localparam logic [7:0] MASK_3B  = 8'hE0;

  localparam logic [3:0] W_RIGHT = 4'd7;
  localparam logic [3:0] W_BELOW = 4'd5;
  localparam logic [3:0] W_BLEFT = 4'd3;

  localparam int MEAN_STEPS = 8;

endpackage

// ----- hdl/box_downscale_fs_dither.sv -----
// Box-filter grey downscaler with optional Floyd-Steinberg dithering.
// Input channel: one 8-bit luma word per source pixel in raster order
// (in_valid_i/in_ready_o). Output channel: one word per finished output
// pixel with its column, row, display level and a frame_done flag
// (out_valid_o/out_ready_i). Configuration is a plain write port; any write
// to a listed register restarts the frame.
// An input word that completes no box is only accumulated. One that
// completes a box also runs the 8-step shared restoring divider for the box
// mean and, with dithering on, the reads and writes of the two error rows,
// which live in single-port memories read and written one entry a cycle.
// After the last pixel of a frame, after reset and after a config write the
// block restarts: the same divider computes the column and row box steps
// and a clearing pass sweeps the sum memory and the MAX_OUT_WIDTH+2 entries
// of each error memory. in_ready_o is low meanwhile.
// The result sits in an output register; a new input word is accepted while
// it waits, and the block only holds when a second result is ready before
// the first was taken.
module box_downscale_fs_dither import bdfs_pkg::*; #(
  parameter int MAX_OUT_WIDTH = 2048,
  parameter int MAX_SRC_DIM   = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        luma_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [10:0]       out_col_o,
  output logic [12:0]       out_row_o,
  output logic [2:0]        level_o,
  output logic              frame_done_o
);

  localparam int DW     = $clog2(MAX_SRC_DIM + 1);
  localparam int TWW    = $clog2(MAX_OUT_WIDTH + 1);
  localparam int OXW    = $clog2(MAX_OUT_WIDTH);
  localparam int EDEPTH = MAX_OUT_WIDTH + 2;
  localparam int EAW    = $clog2(EDEPTH);
  localparam int CNTW   = 2 * $clog2(MAX_SRC_DIM) + 1;
  localparam int SUMW   = CNTW + 8;
  localparam int TGW    = DW + 1;
  localparam int QW     = (DW > MEAN_STEPS) ? DW : MEAN_STEPS;
  localparam int CTW    = $clog2(QW + 1);

  typedef struct packed {
    logic [SUMW-1:0] sum;
    logic [CNTW-1:0] cnt;
  } box_ent_t;

  typedef struct packed {
    logic [TGW-1:0] tag;
    logic [7:0]     val;
  } err_ent_t;

  typedef enum logic [3:0] {
    S_RST0, S_CDIV, S_RDIV, S_CLR, S_IDLE, S_ACC, S_DIV,
    S_ER0, S_ER1, S_ER2, S_ER3, S_DITH, S_WR1, S_WR2, S_EMIT
  } state_e;

  state_e state_q;

  logic [13:0] src_w_q, src_h_q, tgt_h_q;
  logic [11:0] tgt_w_q;
  logic        one_bit_q, dither_q, invert_q;

  logic [DW-1:0]  src_col_q, src_row_q, dst_row_q;
  logic [OXW-1:0] dst_col_q;
  logic [DW-1:0]  col_bnd_q, row_bnd_q, col_rem_q, row_rem_q;
  logic [DW-1:0]  cq_q, cr_q, rq_q, rr_q;

  logic [7:0]     luma_q;
  logic [OXW-1:0] ox_q;
  logic [DW-1:0]  orow_q;
  logic           box_q, band_q, rowend_q, fend_q;

  logic [SUMW-1:0] dv_rem_q, dv_dsr_q;
  logic [QW-1:0]   dv_quo_q;
  logic [CTW-1:0]  dv_cnt_q;

  logic [7:0] lum_q, e1_q, e2_q, n0_q, n1_q, n2_q, wr1_q, wr2_q;
  logic [2:0] lvl_q;
  logic [EAW-1:0] clr_q;

  logic        out_valid_q, frame_done_q;
  logic [10:0] out_col_q;
  logic [12:0] out_row_q;
  logic [2:0]  level_q;

  // effective sizes
  logic [DW-1:0]  sw_eff, sh_eff, th_eff;
  logic [TWW-1:0] tw_eff;
  int unsigned    tw_hi;

  always_comb begin
    sw_eff = (src_w_q == '0) ? DW'(1) :
             ((32'(src_w_q) > MAX_SRC_DIM) ? DW'(MAX_SRC_DIM) : DW'(src_w_q));
    sh_eff = (src_h_q == '0) ? DW'(1) :
             ((32'(src_h_q) > MAX_SRC_DIM) ? DW'(MAX_SRC_DIM) : DW'(src_h_q));
    tw_hi  = (32'(sw_eff) < MAX_OUT_WIDTH) ? 32'(sw_eff) : 32'(MAX_OUT_WIDTH);
    tw_eff = (tgt_w_q == '0) ? TWW'(1) :
             ((32'(tgt_w_q) > tw_hi) ? TWW'(tw_hi) : TWW'(tgt_w_q));
    th_eff = (tgt_h_q == '0) ? DW'(1) :
             ((32'(tgt_h_q) > 32'(sh_eff)) ? sh_eff : DW'(tgt_h_q));
  end

  // position flags for the word at the input
  logic band_end, box_done, row_end, frame_end;
  assign band_end  = ((DW+1)'(src_row_q) + 1'b1) == (DW+1)'(row_bnd_q);
  assign box_done  = ((DW+1)'(src_col_q) + 1'b1) == (DW+1)'(col_bnd_q);
  assign row_end   = ((DW+1)'(src_col_q) + 1'b1) >= (DW+1)'(sw_eff);
  assign frame_end = row_end && (((DW+1)'(src_row_q) + 1'b1) >= (DW+1)'(sh_eff));

  // incremental box boundary steps
  logic [DW:0]   col_sum, row_sum;
  logic          col_wrap, row_wrap;
  logic [DW-1:0] col_rem_n, row_rem_n, col_bnd_n, row_bnd_n;
  always_comb begin
    col_sum   = {1'b0, col_rem_q} + {1'b0, cr_q};
    col_wrap  = col_sum >= (DW+1)'(tw_eff);
    col_rem_n = col_wrap ? DW'(col_sum - (DW+1)'(tw_eff)) : DW'(col_sum);
    col_bnd_n = col_bnd_q + cq_q + DW'(col_wrap);
    row_sum   = {1'b0, row_rem_q} + {1'b0, rr_q};
    row_wrap  = row_sum >= (DW+1)'(th_eff);
    row_rem_n = row_wrap ? DW'(row_sum - (DW+1)'(th_eff)) : DW'(row_sum);
    row_bnd_n = row_bnd_q + rq_q + DW'(row_wrap);
  end

  // shared restoring divider step
  logic            dv_ge;
  logic [SUMW-1:0] dv_rem_n;
  logic [QW-1:0]   dv_quo_n;
  always_comb begin
    dv_ge    = dv_rem_q >= dv_dsr_q;
    dv_rem_n = dv_ge ? dv_rem_q - dv_dsr_q : dv_rem_q;
    dv_quo_n = {dv_quo_q[QW-2:0], dv_ge};
  end

  // box accumulator memory
  box_ent_t bx_mem [MAX_OUT_WIDTH];
  box_ent_t bx_rd_q, bx_wdata;
  logic     bx_we;
  logic [OXW-1:0] bx_waddr;
  logic [SUMW-1:0] acc_sum;
  logic [CNTW-1:0] acc_cnt;

  assign acc_sum = bx_rd_q.sum + SUMW'(luma_q);
  assign acc_cnt = bx_rd_q.cnt + 1'b1;

  always_comb begin
    bx_we    = 1'b0;
    bx_waddr = ox_q;
    bx_wdata = '0;
    if (state_q == S_CLR) begin
      bx_we    = 32'(clr_q) < MAX_OUT_WIDTH;
      bx_waddr = OXW'(clr_q);
    end else if (state_q == S_ACC) begin
      bx_we = 1'b1;
      if (!(box_q && band_q)) begin
        bx_wdata.sum = acc_sum;
        bx_wdata.cnt = acc_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bx_we) begin
      bx_mem[bx_waddr] <= bx_wdata;
    end
    bx_rd_q <= bx_mem[dst_col_q];
  end

  // dither error rows, two banks swapped per band, entries tagged by band
  err_ent_t eb0_mem [EDEPTH];
  err_ent_t eb1_mem [EDEPTH];
  err_ent_t eb0_rd_q, eb1_rd_q, th_rd, nx_rd, th_wdata, nx_wdata;
  logic [EAW-1:0] th_addr, nx_addr, eb0_addr, eb1_addr, ox_e;
  logic           th_we, nx_we, eb0_we, eb1_we;
  err_ent_t       eb0_wdata, eb1_wdata;
  logic [TGW-1:0] tag_this, tag_next;
  logic [7:0]     th_val, nx_val;

  assign ox_e     = EAW'(ox_q);
  assign tag_this = TGW'(orow_q) + TGW'(1);
  assign tag_next = TGW'(orow_q) + TGW'(2);
  assign th_rd    = orow_q[0] ? eb1_rd_q : eb0_rd_q;
  assign nx_rd    = orow_q[0] ? eb0_rd_q : eb1_rd_q;
  assign th_val   = (th_rd.tag == tag_this) ? th_rd.val : 8'd0;
  assign nx_val   = (nx_rd.tag == tag_next) ? nx_rd.val : 8'd0;

  // dither arithmetic
  logic [7:0]  lum_h, old_v, nw_v, qe;
  logic [8:0]  old9;
  logic [11:0] p7, p5, p3;
  always_comb begin
    lum_h = one_bit_q ? (lum_q >> 1) : lum_q;
    old9  = {1'b0, lum_h} + {1'b0, e1_q};
    old_v = old9[8] ? LUMA_MAX : old9[7:0];
    nw_v  = old_v & (one_bit_q ? MASK_1B : MASK_3B);
    qe    = old_v - nw_v;
    p7    = 12'(qe) * 12'(W_RIGHT);
    p5    = 12'(qe) * 12'(W_BELOW);
    p3    = 12'(qe) * 12'(W_BLEFT);
  end

  always_comb begin
    th_addr  = ox_e + EAW'(1);
    nx_addr  = ox_e;
    th_we    = 1'b0;
    nx_we    = 1'b0;
    th_wdata = '{tag: tag_this, val: e2_q + p7[11:4]};
    nx_wdata = '{tag: tag_next, val: n0_q + p3[11:4]};
    unique case (state_q)
      S_ER1: begin
        th_addr = ox_e + EAW'(2);
        nx_addr = ox_e + EAW'(1);
      end
      S_ER2: begin
        nx_addr = ox_e + EAW'(2);
      end
      S_DITH: begin
        th_addr = ox_e + EAW'(2);
        th_we   = 1'b1;
        nx_we   = 1'b1;
      end
      S_WR1: begin
        nx_addr  = ox_e + EAW'(1);
        nx_we    = 1'b1;
        nx_wdata = '{tag: tag_next, val: wr1_q};
      end
      S_WR2: begin
        nx_addr  = ox_e + EAW'(2);
        nx_we    = 1'b1;
        nx_wdata = '{tag: tag_next, val: wr2_q};
      end
      default: ;
    endcase
    if (state_q == S_CLR) begin
      eb0_addr = clr_q; eb1_addr = clr_q;
      eb0_we = 1'b1; eb1_we = 1'b1;
      eb0_wdata = '0; eb1_wdata = '0;
    end else if (orow_q[0]) begin
      eb0_addr = nx_addr; eb0_we = nx_we; eb0_wdata = nx_wdata;
      eb1_addr = th_addr; eb1_we = th_we; eb1_wdata = th_wdata;
    end else begin
      eb0_addr = th_addr; eb0_we = th_we; eb0_wdata = th_wdata;
      eb1_addr = nx_addr; eb1_we = nx_we; eb1_wdata = nx_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eb0_we) begin
      eb0_mem[eb0_addr] <= eb0_wdata;
    end
    eb0_rd_q <= eb0_mem[eb0_addr];
  end

  always_ff @(posedge clk_i) begin
    if (eb1_we) begin
      eb1_mem[eb1_addr] <= eb1_wdata;
    end
    eb1_rd_q <= eb1_mem[eb1_addr];
  end

  // configuration decode
  logic cfg_hit;
  always_comb begin
    unique case (cfg_addr_i)
      REG_SRC_W, REG_SRC_H, REG_TGT_W, REG_TGT_H,
      REG_ONE_BIT, REG_DITHER, REG_INVERT: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  logic       in_acc, emit_ok;
  logic [2:0] lvl_fin;
  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign emit_ok = !out_valid_q || out_ready_i;
  always_comb begin
    if (one_bit_q) begin
      lvl_fin = {2'b00, ~lvl_q[2] ^ invert_q};
    end else begin
      lvl_fin = invert_q ? 3'd7 - lvl_q : lvl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RST0;
      src_w_q   <= 14'd1;
      src_h_q   <= 14'd1;
      tgt_w_q   <= 12'd1;
      tgt_h_q   <= 14'd1;
      one_bit_q <= 1'b0;
      dither_q  <= 1'b1;
      invert_q  <= 1'b0;
      src_col_q <= '0; src_row_q <= '0; dst_col_q <= '0; dst_row_q <= '0;
      col_bnd_q <= '0; row_bnd_q <= '0; col_rem_q <= '0; row_rem_q <= '0;
      cq_q <= '0; cr_q <= '0; rq_q <= '0; rr_q <= '0;
      luma_q <= '0; ox_q <= '0; orow_q <= '0;
      box_q <= 1'b0; band_q <= 1'b0; rowend_q <= 1'b0; fend_q <= 1'b0;
      dv_rem_q <= '0; dv_dsr_q <= '0; dv_quo_q <= '0; dv_cnt_q <= '0;
      lum_q <= '0; e1_q <= '0; e2_q <= '0; n0_q <= '0; n1_q <= '0; n2_q <= '0;
      wr1_q <= '0; wr2_q <= '0; lvl_q <= '0; clr_q <= '0;
      out_valid_q <= 1'b0; out_col_q <= '0; out_row_q <= '0;
      level_q <= '0; frame_done_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_RST0: begin
          src_col_q <= '0; src_row_q <= '0; dst_col_q <= '0; dst_row_q <= '0;
          dv_rem_q  <= SUMW'(sw_eff);
          dv_dsr_q  <= SUMW'(tw_eff) << (DW - 1);
          dv_quo_q  <= '0;
          dv_cnt_q  <= CTW'(DW);
          state_q   <= S_CDIV;
        end
        S_CDIV, S_RDIV: begin
          dv_rem_q <= dv_rem_n;
          dv_dsr_q <= dv_dsr_q >> 1;
          dv_quo_q <= dv_quo_n;
          dv_cnt_q <= dv_cnt_q - 1'b1;
          if (dv_cnt_q == CTW'(1)) begin
            if (state_q == S_CDIV) begin
              cq_q      <= DW'(dv_quo_n);
              cr_q      <= DW'(dv_rem_n);
              col_bnd_q <= DW'(dv_quo_n);
              col_rem_q <= DW'(dv_rem_n);
              dv_rem_q  <= SUMW'(sh_eff);
              dv_dsr_q  <= SUMW'(th_eff) << (DW - 1);
              dv_quo_q  <= '0;
              dv_cnt_q  <= CTW'(DW);
              state_q   <= S_RDIV;
            end else begin
              rq_q      <= DW'(dv_quo_n);
              rr_q      <= DW'(dv_rem_n);
              row_bnd_q <= DW'(dv_quo_n);
              row_rem_q <= DW'(dv_rem_n);
              clr_q     <= '0;
              state_q   <= S_CLR;
            end
          end
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == EDEPTH - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            luma_q   <= luma_i;
            ox_q     <= dst_col_q;
            orow_q   <= dst_row_q;
            box_q    <= box_done;
            band_q   <= band_end;
            rowend_q <= row_end;
            fend_q   <= frame_end;
            state_q  <= S_ACC;
          end
        end
        S_ACC: begin
          if (!fend_q) begin
            if (rowend_q) begin
              src_col_q <= '0;
              dst_col_q <= '0;
              col_bnd_q <= cq_q;
              col_rem_q <= cr_q;
              if (band_q && (((DW+1)'(dst_row_q) + 1'b1) < (DW+1)'(th_eff))) begin
                dst_row_q <= dst_row_q + 1'b1;
                row_bnd_q <= row_bnd_n;
                row_rem_q <= row_rem_n;
              end
              src_row_q <= src_row_q + 1'b1;
            end else begin
              if (box_q && ((TWW'(dst_col_q) + 1'b1) < tw_eff)) begin
                dst_col_q <= dst_col_q + 1'b1;
                col_bnd_q <= col_bnd_n;
                col_rem_q <= col_rem_n;
              end
              src_col_q <= src_col_q + 1'b1;
            end
          end
          if (box_q && band_q) begin
            dv_rem_q <= acc_sum;
            dv_dsr_q <= SUMW'(acc_cnt) << (MEAN_STEPS - 1);
            dv_quo_q <= '0;
            dv_cnt_q <= CTW'(MEAN_STEPS);
            state_q  <= S_DIV;
          end else begin
            state_q  <= fend_q ? S_RST0 : S_IDLE;
          end
        end
        S_DIV: begin
          dv_rem_q <= dv_rem_n;
          dv_dsr_q <= dv_dsr_q >> 1;
          dv_quo_q <= dv_quo_n;
          dv_cnt_q <= dv_cnt_q - 1'b1;
          if (dv_cnt_q == CTW'(1)) begin
            lum_q   <= dv_quo_n[7:0];
            lvl_q   <= dv_quo_n[7:5];
            state_q <= dither_q ? S_ER0 : S_EMIT;
          end
        end
        S_ER0: state_q <= S_ER1;
        S_ER1: begin
          e1_q    <= th_val;
          n0_q    <= nx_val;
          state_q <= S_ER2;
        end
        S_ER2: begin
          e2_q    <= th_val;
          n1_q    <= nx_val;
          state_q <= S_ER3;
        end
        S_ER3: begin
          n2_q    <= nx_val;
          state_q <= S_DITH;
        end
        S_DITH: begin
          wr1_q   <= n1_q + p5[11:4];
          wr2_q   <= n2_q + {4'd0, qe[7:4]};
          lvl_q   <= nw_v[7:5];
          state_q <= S_WR1;
        end
        S_WR1: state_q <= S_WR2;
        S_WR2: state_q <= S_EMIT;
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_q  <= 1'b1;
            out_col_q    <= 11'(32'(ox_q));
            out_row_q    <= 13'(32'(orow_q));
            level_q      <= lvl_fin;
            frame_done_q <= fend_q;
            state_q      <= fend_q ? S_RST0 : S_IDLE;
          end
        end
        default: state_q <= S_RST0;
      endcase
      if (cfg_hit) begin
        unique case (cfg_addr_i)
          REG_SRC_W:   src_w_q   <= cfg_wdata_i;
          REG_SRC_H:   src_h_q   <= cfg_wdata_i;
          REG_TGT_W:   tgt_w_q   <= cfg_wdata_i[11:0];
          REG_TGT_H:   tgt_h_q   <= cfg_wdata_i;
          REG_ONE_BIT: one_bit_q <= cfg_wdata_i[0];
          REG_DITHER:  dither_q  <= cfg_wdata_i[0];
          REG_INVERT:  invert_q  <= cfg_wdata_i[0];
          default: ;
        endcase
        src_col_q <= '0; src_row_q <= '0; dst_col_q <= '0; dst_row_q <= '0;
        state_q   <= S_RST0;
      end
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_col_o    = out_col_q;
  assign out_row_o    = out_row_q;
  assign level_o      = level_q;
  assign frame_done_o = frame_done_q;

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  a_dst_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TWW'(dst_col_q) < tw_eff))
    else $error("output column beyond target width");

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_CDIV || state_q == S_RDIV) |-> dv_cnt_q != '0)
    else $error("divider ran past its last step");

  a_emit_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result raised outside the emit step");

endmodule
